### hdl/sha256_pkg.sv
`timescale 1ns / 1ps

package sha256_pkg;

   localparam int unsigned WORD_W       = 32;
   localparam int unsigned DIGEST_WORDS = 8;
   localparam int unsigned SCHED_WORDS  = 16;
   localparam int unsigned ROUNDS       = 64;
   localparam int unsigned QUEUE_DEPTH  = 4;
   localparam int unsigned COUNT_W      = 61;

   typedef logic [WORD_W-1:0] word_type;

   // one message-schedule word on its way from the front to the core
   typedef struct packed {
      logic     last;
      word_type word;
   } blk_word_type;

   localparam logic MODE_ABSORB = 1'b0;
   localparam logic MODE_FINISH = 1'b1;

   localparam logic [7:0] PAD_BYTE   = 8'h80;
   localparam logic [3:0] LEN_HI_POS = 4'd14;

   localparam word_type ROUND_K [ROUNDS] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam word_type INIT_HASH [DIGEST_WORDS] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

endpackage

### hdl/sha256_front.sv
`timescale 1ns / 1ps

module sha256_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic                      req_mode,
   input  logic [7:0]                req_data_byte,
   input  logic                      q_full,
   output logic                      q_push,
   output sha256_pkg::blk_word_type  q_data
);

   import sha256_pkg::*;

   typedef enum logic [4:0] {
      F_ABSORB = 5'b00001,
      F_FIRST  = 5'b00010,
      F_ZERO   = 5'b00100,
      F_LENHI  = 5'b01000,
      F_LENLO  = 5'b10000
   } front_state_type;

   front_state_type      state_ff, state_in;
   logic [5:0]           fill_ff, fill_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [3:0]           wpos_ff, wpos_in;
   logic [23:0]          part_ff, part_in;

   logic                 accept;
   logic [63:0]          bit_len;
   word_type             first_word;

   assign req_full = q_full || (state_ff != F_ABSORB);
   assign accept   = req_push && !req_full;
   assign bit_len  = {count_ff, 3'b000};

   always_comb begin
      unique case (fill_ff[1:0])
         2'd0: first_word = {PAD_BYTE, 24'h0};
         2'd1: first_word = {part_ff[7:0], PAD_BYTE, 16'h0};
         2'd2: first_word = {part_ff[15:0], PAD_BYTE, 8'h0};
         2'd3: first_word = {part_ff[23:0], PAD_BYTE};
         default: first_word = '0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      count_in = count_ff;
      wpos_in  = wpos_ff;
      part_in  = part_ff;
      q_push   = 1'b0;
      q_data   = '{last: 1'b0, word: '0};
      unique case (state_ff)
         F_ABSORB: begin
            if (accept) begin
               if (req_mode == MODE_ABSORB) begin
                  part_in  = {part_ff[15:0], req_data_byte};
                  fill_in  = fill_ff + 6'd1;
                  count_in = count_ff + COUNT_W'(1);
                  if (fill_ff[1:0] == 2'd3) begin
                     q_push = 1'b1;
                     q_data = '{last: 1'b0, word: {part_ff, req_data_byte}};
                  end
               end else begin
                  wpos_in  = fill_ff[5:2];
                  state_in = F_FIRST;
               end
            end
         end
         F_FIRST: begin
            if (!q_full) begin
               q_push   = 1'b1;
               q_data   = '{last: 1'b0, word: first_word};
               wpos_in  = wpos_ff + 4'd1;
               state_in = (wpos_ff + 4'd1 == LEN_HI_POS) ? F_LENHI : F_ZERO;
            end
         end
         F_ZERO: begin
            // zero words run across a block boundary when the length does not fit
            if (!q_full) begin
               q_push   = 1'b1;
               q_data   = '{last: 1'b0, word: '0};
               wpos_in  = wpos_ff + 4'd1;
               if (wpos_ff + 4'd1 == LEN_HI_POS) begin
                  state_in = F_LENHI;
               end
            end
         end
         F_LENHI: begin
            if (!q_full) begin
               q_push   = 1'b1;
               q_data   = '{last: 1'b0, word: bit_len[63:32]};
               state_in = F_LENLO;
            end
         end
         F_LENLO: begin
            if (!q_full) begin
               q_push   = 1'b1;
               q_data   = '{last: 1'b1, word: bit_len[31:0]};
               fill_in  = '0;
               count_in = '0;
               state_in = F_ABSORB;
            end
         end
         default: state_in = F_ABSORB;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_ABSORB;
         fill_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      wpos_ff <= wpos_in;
      part_ff <= part_in;
   end

endmodule

### hdl/sha256_fifo.sv
`timescale 1ns / 1ps

module sha256_fifo #(
   parameter int unsigned DEPTH = sha256_pkg::QUEUE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  sha256_pkg::blk_word_type  din,
   output logic                      full,
   input  logic                      pop,
   output sha256_pkg::blk_word_type  dout,
   output logic                      empty
);

   import sha256_pkg::*;

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   blk_word_type   slot_ff [DEPTH];
   logic [PW-1:0]  wr_ff, wr_in;
   logic [PW-1:0]  rd_ff, rd_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           do_push, do_pop;

   assign full    = (cnt_ff == CW'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = slot_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= din;
      end
   end

endmodule

### hdl/sha256_core.sv
`timescale 1ns / 1ps

module sha256_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      q_empty,
   input  sha256_pkg::blk_word_type  q_data,
   output logic                      q_pop,
   input  logic                      rsp_pop,
   output logic                      rsp_empty,
   output logic [31:0]               rsp_digest_word,
   output logic [2:0]                rsp_word_index,
   output logic                      rsp_last_word
);

   import sha256_pkg::*;

   typedef enum logic [1:0] {
      C_ROUND  = 2'b01,
      C_UPDATE = 2'b10
   } core_state_type;

   function automatic word_type ror(input word_type x, input int unsigned n);
      ror = (x >> n) | (x << (WORD_W - n));
   endfunction

   core_state_type  state_ff, state_in;
   logic [5:0]      t_ff, t_in;
   logic            final_ff, final_in;
   word_type        cv_ff   [DIGEST_WORDS];
   word_type        cv_in   [DIGEST_WORDS];
   word_type        v_ff    [DIGEST_WORDS];
   word_type        v_in    [DIGEST_WORDS];
   word_type        w_ff    [SCHED_WORDS];
   word_type        w_in    [SCHED_WORDS];
   word_type        dig_ff  [DIGEST_WORDS];
   word_type        dig_in  [DIGEST_WORDS];
   logic            out_valid_ff, out_valid_in;
   logic [2:0]      idx_ff, idx_in;

   logic            need_word, stall, out_take;
   word_type        sched, w_new, s0, s1, big0, big1, ch, maj, t1, t2;
   word_type        sum [DIGEST_WORDS];

   assign need_word = (t_ff[5:4] == 2'b00);
   assign stall     = need_word && q_empty;
   assign q_pop     = (state_ff == C_ROUND) && need_word && !q_empty;
   assign out_take  = rsp_pop && out_valid_ff;

   assign rsp_empty       = !out_valid_ff;
   assign rsp_digest_word = dig_ff[0];
   assign rsp_word_index  = idx_ff;
   assign rsp_last_word   = (idx_ff == 3'(DIGEST_WORDS - 1));

   assign s0    = ror(w_ff[1], 7) ^ ror(w_ff[1], 18) ^ (w_ff[1] >> 3);
   assign s1    = ror(w_ff[14], 17) ^ ror(w_ff[14], 19) ^ (w_ff[14] >> 10);
   assign sched = s1 + w_ff[9] + s0 + w_ff[0];
   assign w_new = need_word ? q_data.word : sched;

   assign big1 = ror(v_ff[4], 6) ^ ror(v_ff[4], 11) ^ ror(v_ff[4], 25);
   assign ch   = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
   assign t1   = v_ff[7] + big1 + ch + ROUND_K[t_ff] + w_new;
   assign big0 = ror(v_ff[0], 2) ^ ror(v_ff[0], 13) ^ ror(v_ff[0], 22);
   assign maj  = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
   assign t2   = big0 + maj;

   always_comb begin
      for (int i = 0; i < DIGEST_WORDS; i++) begin
         sum[i] = cv_ff[i] + v_ff[i];
      end
   end

   always_comb begin
      state_in     = state_ff;
      t_in         = t_ff;
      final_in     = final_ff;
      cv_in        = cv_ff;
      v_in         = v_ff;
      w_in         = w_ff;
      dig_in       = dig_ff;
      out_valid_in = out_valid_ff;
      idx_in       = idx_ff;

      // drain the digest one word per request
      if (out_take) begin
         for (int i = 0; i < DIGEST_WORDS - 1; i++) begin
            dig_in[i] = dig_ff[i + 1];
         end
         idx_in = idx_ff + 3'd1;
         if (idx_ff == 3'(DIGEST_WORDS - 1)) begin
            out_valid_in = 1'b0;
         end
      end

      unique case (state_ff)
         C_ROUND: begin
            if (!stall) begin
               for (int i = 0; i < SCHED_WORDS - 1; i++) begin
                  w_in[i] = w_ff[i + 1];
               end
               w_in[SCHED_WORDS - 1] = w_new;
               v_in[7] = v_ff[6];
               v_in[6] = v_ff[5];
               v_in[5] = v_ff[4];
               v_in[4] = v_ff[3] + t1;
               v_in[3] = v_ff[2];
               v_in[2] = v_ff[1];
               v_in[1] = v_ff[0];
               v_in[0] = t1 + t2;
               if (t_ff == 6'd15) begin
                  final_in = q_data.last;
               end
               t_in = t_ff + 6'd1;
               if (t_ff == 6'(ROUNDS - 1)) begin
                  state_in = C_UPDATE;
               end
            end
         end
         C_UPDATE: begin
            // hold a final block until the previous digest is gone
            if (!(final_ff && out_valid_ff)) begin
               if (final_ff) begin
                  dig_in       = sum;
                  out_valid_in = 1'b1;
                  idx_in       = '0;
                  cv_in        = INIT_HASH;
                  v_in         = INIT_HASH;
               end else begin
                  cv_in = sum;
                  v_in  = sum;
               end
               t_in     = '0;
               state_in = C_ROUND;
            end
         end
         default: state_in = C_ROUND;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= C_ROUND;
         t_ff         <= '0;
         final_ff     <= 1'b0;
         cv_ff        <= INIT_HASH;
         v_ff         <= INIT_HASH;
         out_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         t_ff         <= t_in;
         final_ff     <= final_in;
         cv_ff        <= cv_in;
         v_ff         <= v_in;
         out_valid_ff <= out_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff   <= w_in;
      dig_ff <= dig_in;
   end

endmodule

### hdl/sha256_byte_stream_hash.sv
`timescale 1ns / 1ps

// Channel     Ports                                         Handshake
// request     req_mode, req_data_byte                       req_push / req_full
// result      rsp_digest_word, rsp_word_index, rsp_last_word rsp_pop / rsp_empty
//
// A data byte is taken whenever req_full is low; every fourth byte goes as a word into the queue.
// The core runs one round per cycle unless it needs a word and the queue is empty: a 64-byte
// block takes 64 rounds and one chaining update, so bytes stall on req_full once the queue fills behind it.
// A finish request adds 3 to 18 padding words, then one or two blocks are compressed
// before eight digest words appear, one per pop.
// Reset is synchronous and brings back the initial hash value; there is no clearing pass.

module sha256_byte_stream_hash #(
   parameter int unsigned QUEUE_DEPTH = sha256_pkg::QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_push,
   output logic         req_full,
   input  logic         req_mode,
   input  logic [7:0]   req_data_byte,
   input  logic         rsp_pop,
   output logic         rsp_empty,
   output logic [31:0]  rsp_digest_word,
   output logic [2:0]   rsp_word_index,
   output logic         rsp_last_word
);

   import sha256_pkg::*;

   logic          q_push, q_full, q_pop, q_empty;
   blk_word_type  q_din, q_dout;

   sha256_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_mode      (req_mode),
      .req_data_byte (req_data_byte),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_data        (q_din)
   );

   sha256_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .din   (q_din),
      .full  (q_full),
      .pop   (q_pop),
      .dout  (q_dout),
      .empty (q_empty)
   );

   sha256_core u_core (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_data          (q_dout),
      .q_pop           (q_pop),
      .rsp_pop         (rsp_pop),
      .rsp_empty       (rsp_empty),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_last_word   (rsp_last_word)
   );

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("front pushed into a full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("core popped an empty queue");

   a_last_drains: assert property (@(posedge clock) disable iff (reset)
      (rsp_pop && !rsp_empty && rsp_last_word) |=> rsp_empty)
      else $error("digest still shown after its last word was taken");

   a_first_word: assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_empty) |-> (rsp_word_index == 3'd0))
      else $error("digest did not start at word zero");

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps

package digest_check_pkg;

   import sha256_pkg::MODE_ABSORB;
   import sha256_pkg::MODE_FINISH;

   localparam logic [7:0] PAD_MARKER = 8'h80;
   localparam int unsigned LENGTH_SLOT = 56;
   localparam int unsigned BLOCK_BYTES = 64;
   localparam int unsigned BYTE_COUNT_W = 61;

   localparam logic [31:0] SHA_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] SHA_IV [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   typedef struct {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_word_type;

   class digest_scoreboard;
      logic [31:0] chain [8];
      logic [7:0]  block_bytes [BLOCK_BYTES];
      int unsigned fill;
      logic [BYTE_COUNT_W-1:0] byte_count;
      digest_word_type digest_queue [$];
      int unsigned errors;

      function new();
         chain = SHA_IV;
         fill = 0;
         byte_count = '0;
         errors = 0;
      endfunction

      function logic [31:0] rotr(logic [31:0] x, int unsigned n);
         return (x >> n) | (x << (32 - n));
      endfunction

      function void compress();
         logic [31:0] w [64];
         logic [31:0] v [8];
         logic [31:0] s0, s1, t1, t2;
         for (int i = 0; i < 16; i++)
            w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2],
                    block_bytes[4*i+3]};
         for (int i = 16; i < 64; i++) begin
            s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
         end
         v = chain;
         for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[i] + w[i];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
         end
         for (int i = 0; i < 8; i++)
            chain[i] = chain[i] + v[i];
      endfunction

      // advance the hash state by one accepted request
      function void note_request(logic mode, logic [7:0] data);
         logic [63:0] length_bits;
         digest_word_type item;
         if (mode == MODE_ABSORB) begin
            block_bytes[fill] = data;
            fill = (fill + 1) % BLOCK_BYTES;
            byte_count = byte_count + 1'b1;
            if (fill == 0)
               compress();
            return;
         end
         length_bits = {byte_count, 3'b000};
         block_bytes[fill] = PAD_MARKER;
         fill = fill + 1;
         // no room left for the length: close this block and pad a fresh one
         if (fill > LENGTH_SLOT) begin
            for (int i = fill; i < BLOCK_BYTES; i++)
               block_bytes[i] = 8'h00;
            compress();
            fill = 0;
         end
         for (int i = fill; i < LENGTH_SLOT; i++)
            block_bytes[i] = 8'h00;
         for (int i = 0; i < 8; i++)
            block_bytes[LENGTH_SLOT + i] = length_bits[63 - 8*i -: 8];
         compress();
         for (int i = 0; i < 8; i++) begin
            item.word = chain[i];
            item.index = i[2:0];
            item.last = (i == 7);
            digest_queue = {digest_queue, item};
         end
         chain = SHA_IV;
         fill = 0;
         byte_count = '0;
      endfunction

      task report(string msg);
         $display("MISMATCH at %0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_result(logic [31:0] word, logic [2:0] index, logic last);
         digest_word_type item;
         if (digest_queue.size() == 0) begin
            report($sformatf("digest word %h index %0d with nothing pending", word, index));
            return;
         end
         item = digest_queue.pop_front();
         if (word !== item.word)
            report($sformatf("word %0d: got %h, want %h", item.index, word, item.word));
         if (index !== item.index)
            report($sformatf("word index: got %0d, want %0d", index, item.index));
         if (last !== item.last)
            report($sformatf("last flag on word %0d: got %b, want %b",
                             item.index, last, item.last));
      endtask

      function int unsigned pending();
         return digest_queue.size();
      endfunction
   endclass

endpackage

module testbench;

   import sha256_pkg::MODE_ABSORB;
   import sha256_pkg::MODE_FINISH;
   import digest_check_pkg::*;

   localparam int unsigned REQUEST_TARGET = 480;
   localparam int unsigned CYCLE_LIMIT = 150000;
   localparam int unsigned HOLD_AT_RESULT = 40;
   localparam int unsigned HOLD_CYCLES = 600;
   localparam int unsigned DRAIN_CYCLES = 200;

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   logic        req_mode;
   logic [7:0]  req_data_byte;
   logic        rsp_pop;
   logic        rsp_empty;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;

   digest_scoreboard board;
   int unsigned requests_sent;
   int unsigned results_taken;
   int unsigned cycle_count = 0;
   int unsigned send_burst;
   int unsigned take_burst;
   bit          holding;

   sha256_byte_stream_hash DUT (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_mode        (req_mode),
      .req_data_byte   (req_data_byte),
      .rsp_pop         (rsp_pop),
      .rsp_empty       (rsp_empty),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_last_word   (rsp_last_word)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // mix random waits with occasional back-to-back stretches
   function automatic int unsigned draw_gap(ref int unsigned burst_left);
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0)
         burst_left = $urandom_range(8, 24);
      return $urandom_range(0, 9);
   endfunction

   task automatic send_request(input logic mode, input logic [7:0] data);
      int unsigned gap;
      gap = draw_gap(send_burst);
      if (holding)
         gap = 0;
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_push <= 1'b1;
      req_mode <= mode;
      req_data_byte <= data;
      @(posedge clock);
      while (req_full) @(posedge clock);
      board.note_request(mode, data);
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic send_message(input int unsigned length);
      for (int i = 0; i < length; i++)
         send_request(MODE_ABSORB, 8'($urandom_range(0, 255)));
      send_request(MODE_FINISH, 8'($urandom_range(0, 255)));
   endtask

   task automatic take_result();
      int unsigned gap;
      gap = draw_gap(take_burst);
      // starve the result side once so the block backs up into req_full
      if (results_taken == HOLD_AT_RESULT) begin
         holding = 1'b1;
         gap = HOLD_CYCLES;
      end
      if (gap > 0) begin
         rsp_pop <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      holding = 1'b0;
      rsp_pop <= 1'b1;
      @(posedge clock);
      while (rsp_empty) @(posedge clock);
      board.check_result(rsp_digest_word, rsp_word_index, rsp_last_word);
      results_taken++;
      @(negedge clock);
   endtask

   initial begin
      int unsigned length;
      board = new();
      requests_sent = 0;
      results_taken = 0;
      send_burst = 0;
      take_burst = 0;
      holding = 1'b0;
      reset <= 1'b1;
      req_push <= 1'b0;
      req_mode <= MODE_ABSORB;
      req_data_byte <= 8'h00;
      rsp_pop <= 1'b0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      fork
         forever take_result();
      join_none

      // two empty messages, then short messages of three, two and two bytes
      send_request(MODE_FINISH, 8'h00);
      send_request(MODE_FINISH, 8'hff);
      send_request(MODE_ABSORB, 8'h61);
      send_request(MODE_ABSORB, 8'h62);
      send_request(MODE_ABSORB, 8'h63);
      send_request(MODE_FINISH, 8'h00);
      send_request(MODE_ABSORB, 8'h00);
      send_request(MODE_ABSORB, 8'hff);
      send_request(MODE_FINISH, 8'hff);
      send_request(MODE_ABSORB, 8'h55);
      send_request(MODE_ABSORB, 8'haa);
      send_request(MODE_FINISH, 8'h5a);

      // lengths cluster on the one-block and two-block padding boundaries
      while (requests_sent < REQUEST_TARGET) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: length = $urandom_range(0, 12);
            5, 6, 7: length = $urandom_range(50, 70);
            8: length = $urandom_range(112, 128);
            default: length = 0;
         endcase
         send_message(length);
      end
      req_push <= 1'b0;

      while (board.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (board.errors == 0 && board.pending() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
